// ===== hw/rtl/linear_triangle_element_stiffness_top_defines.svh =====
// Assertion macros shared by the triangle stiffness RTL.
// Depends on nothing; the using module must have signals named clock and reset.
`ifndef LINEAR_TRIANGLE_ELEMENT_STIFFNESS_TOP_DEFINES_SVH
`define LINEAR_TRIANGLE_ELEMENT_STIFFNESS_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LTES_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define LTES_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/ltes_pkg.sv =====
// Types and fixed widths for the triangle stiffness block.
// Depends on nothing; used by every RTL module of the block.
package ltes_pkg;

   localparam int COORD_W  = 32;
   localparam int DIFF_W   = 33;
   localparam int SUM_W    = 35;
   localparam int PROD_W   = 66;
   localparam int A2_W     = 67;
   localparam int ABS_W    = 66;
   localparam int MUL_W    = 36;
   localparam int MULP_W   = 72;
   localparam int ACC_W    = 104;
   localparam int NUM_W    = 128;
   localparam int DEN_W    = 70;
   localparam int QSTEPS   = 33;
   localparam int QUO_W    = 34;
   localparam int SPLIT_W  = 34;

   // The load divisor 24 << (2*FRAC_BITS) is three shifted left by this plus 2*FRAC_BITS.
   localparam int LOAD_DEN_SHIFT = 3;
   // Width of the truncated load quotient that is divided by three.
   localparam int TRUNC_W = 35;
   // Reciprocal of three, (2^36 + 2) / 3, exact for dividends below 2^35.
   localparam int RECIP_SHIFT = 36;
   localparam logic [MUL_W-1:0] RECIP_THREE = 36'h5_5555_5556;

   localparam logic [1:0] ROW_LAST = 2'd2;
   localparam logic [1:0] OP_LOAD  = 2'd3;

   typedef struct packed {
      logic signed [31:0] x_zero;
      logic signed [31:0] y_zero;
      logic signed [31:0] x_one;
      logic signed [31:0] y_one;
      logic signed [31:0] x_two;
      logic signed [31:0] y_two;
      logic signed [31:0] src_zero;
      logic signed [31:0] src_one;
      logic signed [31:0] src_two;
   } req_type;

   typedef struct packed {
      logic [1:0]         row_index;
      logic signed [31:0] stiff_col_zero;
      logic signed [31:0] stiff_col_one;
      logic signed [31:0] stiff_col_two;
      logic signed [31:0] load_value;
      logic signed [31:0] tri_area;
      logic               degenerate;
      logic               last_row;
   } rsp_type;

   // One classified triangle as it waits between front and back.
   typedef struct packed {
      logic [2:0][DIFF_W-1:0] dx;
      logic [2:0][DIFF_W-1:0] dy;
      logic [2:0][SUM_W-1:0]  ssum;
      logic [A2_W-1:0]        a2;
   } job_type;

endpackage

// ===== hw/rtl/ltes_front.sv =====
// Front end: accepts triangles, forms edge terms, source sums and twice the area.
// Depends on ltes_pkg.
module ltes_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  ltes_pkg::req_type req_data,
   output logic              q_push,
   input  logic              q_full,
   output ltes_pkg::job_type q_data
);

   logic s1_valid_ff, s2_valid_ff;
   logic s1_adv, s2_adv, accept;
   logic [2:0][ltes_pkg::DIFF_W-1:0] dx_in, dy_in, s1_dx_ff, s1_dy_ff, s2_dx_ff, s2_dy_ff;
   logic [2:0][ltes_pkg::SUM_W-1:0]  sum_in, s1_sum_ff, s2_sum_ff;
   logic signed [ltes_pkg::PROD_W-1:0] p1_ff, p2_ff;

   always_comb begin
      s2_adv = !s2_valid_ff || !q_full;
      s1_adv = !s1_valid_ff || s2_adv;
      accept = push && s1_adv;
      full   = !s1_adv;
      q_push = s2_valid_ff;
   end

   always_comb begin
      dx_in[0] = (ltes_pkg::DIFF_W)'(req_data.x_two) - (ltes_pkg::DIFF_W)'(req_data.x_one);
      dx_in[1] = (ltes_pkg::DIFF_W)'(req_data.x_zero) - (ltes_pkg::DIFF_W)'(req_data.x_two);
      dx_in[2] = (ltes_pkg::DIFF_W)'(req_data.x_one) - (ltes_pkg::DIFF_W)'(req_data.x_zero);
      dy_in[0] = (ltes_pkg::DIFF_W)'(req_data.y_one) - (ltes_pkg::DIFF_W)'(req_data.y_two);
      dy_in[1] = (ltes_pkg::DIFF_W)'(req_data.y_two) - (ltes_pkg::DIFF_W)'(req_data.y_zero);
      dy_in[2] = (ltes_pkg::DIFF_W)'(req_data.y_zero) - (ltes_pkg::DIFF_W)'(req_data.y_one);
      sum_in[0] = (ltes_pkg::SUM_W)'(req_data.src_zero) + (ltes_pkg::SUM_W)'(req_data.src_zero)
                + (ltes_pkg::SUM_W)'(req_data.src_one) + (ltes_pkg::SUM_W)'(req_data.src_two);
      sum_in[1] = (ltes_pkg::SUM_W)'(req_data.src_one) + (ltes_pkg::SUM_W)'(req_data.src_one)
                + (ltes_pkg::SUM_W)'(req_data.src_two) + (ltes_pkg::SUM_W)'(req_data.src_zero);
      sum_in[2] = (ltes_pkg::SUM_W)'(req_data.src_two) + (ltes_pkg::SUM_W)'(req_data.src_two)
                + (ltes_pkg::SUM_W)'(req_data.src_zero) + (ltes_pkg::SUM_W)'(req_data.src_one);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (s1_adv) s1_valid_ff <= push;
         if (s2_adv) s2_valid_ff <= s1_valid_ff;
      end
      if (accept) begin
         s1_dx_ff  <= dx_in;
         s1_dy_ff  <= dy_in;
         s1_sum_ff <= sum_in;
      end
      // Twice the area is dx2*dy1 - dx1*dy2.
      if (s2_adv && s1_valid_ff) begin
         s2_dx_ff  <= s1_dx_ff;
         s2_dy_ff  <= s1_dy_ff;
         s2_sum_ff <= s1_sum_ff;
         p1_ff     <= $signed(s1_dx_ff[2]) * $signed(s1_dy_ff[1]);
         p2_ff     <= $signed(s1_dx_ff[1]) * $signed(s1_dy_ff[2]);
      end
   end

   always_comb begin
      q_data.dx   = s2_dx_ff;
      q_data.dy   = s2_dy_ff;
      q_data.ssum = s2_sum_ff;
      q_data.a2   = (ltes_pkg::A2_W)'(p1_ff) - (ltes_pkg::A2_W)'(p2_ff);
   end

endmodule

// ===== hw/rtl/ltes_queue.sv =====
// Two-entry queue of classified triangles between front and back.
// Depends on ltes_pkg and the shared assertion macro header.
`include "linear_triangle_element_stiffness_top_defines.svh"
module ltes_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ltes_pkg::job_type wdata,
   output logic              full,
   output logic              valid,
   output ltes_pkg::job_type rdata,
   input  logic              pop
);

   ltes_pkg::job_type mem_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;
   logic       do_push, do_pop;

   always_comb begin
      full    = (count_ff == 2'd2);
      valid   = (count_ff != 2'd0);
      do_push = push && !full;
      do_pop  = pop && valid;
      rdata   = mem_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (do_push) wr_ptr_ff <= !wr_ptr_ff;
         if (do_pop)  rd_ptr_ff <= !rd_ptr_ff;
         count_ff <= count_ff + 2'(do_push) - 2'(do_pop);
      end
      if (do_push) mem_ff[wr_ptr_ff] <= wdata;
   end

   `LTES_ASSERT_IMPL(a_count_max, 1'b1, count_ff <= 2'd2, "queue count beyond depth")
   `LTES_ASSERT_NEXT(a_count_up, do_push && !do_pop, count_ff == $past(count_ff) + 2'd1, "queue lost a push")
   `LTES_ASSERT_NEXT(a_count_down, do_pop && !do_push, count_ff == $past(count_ff) - 2'd1, "queue lost a pop")

endmodule

// ===== hw/rtl/ltes_div.sv =====
// Radix-2 restoring divider with round-half-away and signed 32-bit saturation.
// Depends on ltes_pkg.
module ltes_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic                         num_neg,
   input  logic [ltes_pkg::NUM_W-1:0]   num_mag,
   input  logic [ltes_pkg::DEN_W-1:0]   den,
   output logic                         done,
   output logic [31:0]                  quo
);

   localparam int RW = ltes_pkg::DEN_W + ltes_pkg::QSTEPS;

   typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIN} dstate_type;

   dstate_type state_ff;
   logic [RW-1:0]                 r_ff;
   logic [RW-2:0]                 d_ff;
   logic [ltes_pkg::DEN_W-1:0]    den_ff;
   logic [ltes_pkg::QUO_W-1:0]    q_ff;
   logic [5:0]                    cnt_ff;
   logic                          neg_ff, sat_ff, done_ff;
   logic [31:0]                   quo_ff;

   logic                          big_in, ge_in, round_in;
   logic [ltes_pkg::QUO_W-1:0]    qr_in;
   logic [31:0]                   res_in;

   always_comb begin
      big_in   = num_mag >= ((ltes_pkg::NUM_W)'(den) << ltes_pkg::QSTEPS);
      ge_in    = r_ff >= {1'b0, d_ff};
      round_in = {r_ff, 1'b0} >= (RW + 1)'(den_ff);
      qr_in    = q_ff + (ltes_pkg::QUO_W)'(round_in);
      if (sat_ff) begin
         res_in = neg_ff ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else if (neg_ff) begin
         res_in = (qr_in > (ltes_pkg::QUO_W)'(64'h8000_0000)) ? 32'h8000_0000
                                                             : 32'd0 - qr_in[31:0];
      end else begin
         res_in = (qr_in > (ltes_pkg::QUO_W)'(64'h7FFF_FFFF)) ? 32'h7FFF_FFFF : qr_in[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            D_IDLE: begin
               if (start) begin
                  neg_ff <= num_neg;
                  sat_ff <= big_in;
                  den_ff <= den;
                  r_ff   <= num_mag[RW-1:0];
                  d_ff   <= (RW - 1)'(den) << (ltes_pkg::QSTEPS - 1);
                  q_ff   <= '0;
                  cnt_ff <= 6'(ltes_pkg::QSTEPS - 1);
                  state_ff <= big_in ? D_FIN : D_RUN;
               end
            end
            D_RUN: begin
               if (ge_in) r_ff <= r_ff - {1'b0, d_ff};
               q_ff <= {q_ff[ltes_pkg::QUO_W-2:0], ge_in};
               d_ff <= d_ff >> 1;
               if (cnt_ff == 6'd0) state_ff <= D_FIN;
               else cnt_ff <= cnt_ff - 6'd1;
            end
            D_FIN: begin
               quo_ff   <= res_in;
               done_ff  <= 1'b1;
               state_ff <= D_IDLE;
            end
            default: state_ff <= D_IDLE;
         endcase
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

// ===== hw/rtl/ltes_back.sv =====
// Back end: sequences products and divisions for each row and holds the result register.
// Depends on ltes_pkg, ltes_div and the shared assertion macro header.
`include "linear_triangle_element_stiffness_top_defines.svh"
module ltes_back #(
   parameter int FRAC_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   input  ltes_pkg::job_type job_data,
   output logic              job_pop,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output ltes_pkg::rsp_type rsp_data
);

   localparam int LoadShift = 2 * FRAC_BITS + ltes_pkg::LOAD_DEN_SHIFT;

   typedef enum logic [2:0] {S_IDLE, S_M1, S_M2, S_M3, S_DIV, S_RCP, S_FIX, S_EMIT} state_type;

   state_type state_ff;
   ltes_pkg::job_type job_ff;
   logic [1:0]  row_ff, op_ff;
   logic        a2neg_ff, degen_ff, div_start_ff, rsp_valid_ff;
   logic [ltes_pkg::ABS_W-1:0] absa2_ff;
   logic [31:0] area_ff, load_ff;
   logic [2:0][31:0] col_ff;
   logic signed [ltes_pkg::MULP_W-1:0] prod_ff;
   logic signed [ltes_pkg::ACC_W-1:0]  acc_ff;
   ltes_pkg::rsp_type rsp_ff;

   logic        is_load, out_free, div_done, sumneg_in, a2neg_in, num_neg_in;
   logic [1:0]  col_in;
   logic [ltes_pkg::A2_W-1:0]  a2_in;
   logic [ltes_pkg::ABS_W-1:0] absa2_in;
   logic [ltes_pkg::A2_W-1:0]  area_sum_in, area_mag_in;
   logic [31:0] area_in, quo;
   logic signed [ltes_pkg::SUM_W-1:0] sum_in;
   logic [ltes_pkg::SPLIT_W-1:0] sumabs_in;
   logic signed [ltes_pkg::MUL_W-1:0]  ma_in, mb_in;
   logic signed [ltes_pkg::MULP_W-1:0] prod_in;
   logic [ltes_pkg::ACC_W-1:0] accabs_in;
   logic [ltes_pkg::NUM_W-1:0] num_in;
   logic [ltes_pkg::DEN_W-1:0] den_in;
   logic [ltes_pkg::ACC_W-1:0] trunc_in;
   logic        tbig_in, rbit_in, rup_in, lneg_in;
   logic [ltes_pkg::QUO_W-1:0] lquo_in, lq_in;
   logic [1:0]  rem_in;
   logic [31:0] load_in;

   // Area and degenerate test on the triangle at the head of the queue.
   always_comb begin
      a2_in       = job_data.a2;
      a2neg_in    = a2_in[ltes_pkg::A2_W-1];
      absa2_in    = a2neg_in ? (ltes_pkg::ABS_W)'(-$signed(a2_in))
                             : a2_in[ltes_pkg::ABS_W-1:0];
      area_sum_in = (ltes_pkg::A2_W)'(absa2_in) + ((ltes_pkg::A2_W)'(1) << FRAC_BITS);
      area_mag_in = area_sum_in >> (FRAC_BITS + 1);
      if (a2neg_in)
         area_in = (area_mag_in > (ltes_pkg::A2_W)'(64'h8000_0000)) ? 32'h8000_0000
                                                                  : 32'd0 - area_mag_in[31:0];
      else
         area_in = (area_mag_in > (ltes_pkg::A2_W)'(64'h7FFF_FFFF)) ? 32'h7FFF_FFFF
                                                                  : area_mag_in[31:0];
   end

   // The load divisor is three times a power of two: shift first, then divide by three.
   always_comb begin
      trunc_in = acc_ff[ltes_pkg::ACC_W-1:0] >> LoadShift;
      tbig_in  = trunc_in >= ((ltes_pkg::ACC_W)'(3) << ltes_pkg::QSTEPS);
      rbit_in  = acc_ff[LoadShift-1];
      lquo_in  = prod_ff[ltes_pkg::RECIP_SHIFT +: ltes_pkg::QUO_W];
      rem_in   = trunc_in[1:0] - lquo_in[1:0] - {lquo_in[0], 1'b0};
      rup_in   = (rem_in == 2'd2) || ((rem_in == 2'd1) && rbit_in);
      lq_in    = lquo_in + (ltes_pkg::QUO_W)'(rup_in);
      lneg_in  = a2neg_ff ^ sumneg_in;
      if (tbig_in)
         load_in = lneg_in ? 32'h8000_0000 : 32'h7FFF_FFFF;
      else if (lneg_in)
         load_in = (lq_in > (ltes_pkg::QUO_W)'(64'h8000_0000)) ? 32'h8000_0000
                                                               : 32'd0 - lq_in[31:0];
      else
         load_in = (lq_in > (ltes_pkg::QUO_W)'(64'h7FFF_FFFF)) ? 32'h7FFF_FFFF
                                                               : lq_in[31:0];
   end

   // Operand selection for the shared multiplier.
   always_comb begin
      is_load   = (op_ff == ltes_pkg::OP_LOAD);
      col_in    = is_load ? 2'd0 : op_ff;
      sum_in    = $signed(job_ff.ssum[row_ff]);
      sumneg_in = sum_in[ltes_pkg::SUM_W-1];
      sumabs_in = sumneg_in ? (ltes_pkg::SPLIT_W)'(-sum_in) : sum_in[ltes_pkg::SPLIT_W-1:0];
      if (state_ff == S_RCP) begin
         ma_in = $signed((ltes_pkg::MUL_W)'(trunc_in[ltes_pkg::TRUNC_W-1:0]));
         mb_in = $signed(ltes_pkg::RECIP_THREE);
      end else if (is_load) begin
         mb_in = $signed((ltes_pkg::MUL_W)'(sumabs_in));
         if (state_ff == S_M1)
            ma_in = $signed((ltes_pkg::MUL_W)'(absa2_ff[ltes_pkg::SPLIT_W-1:0]));
         else
            ma_in = $signed((ltes_pkg::MUL_W)'(absa2_ff[ltes_pkg::ABS_W-1:ltes_pkg::SPLIT_W]));
      end else if (state_ff == S_M1) begin
         ma_in = (ltes_pkg::MUL_W)'($signed(job_ff.dy[row_ff]));
         mb_in = (ltes_pkg::MUL_W)'($signed(job_ff.dy[col_in]));
      end else begin
         ma_in = (ltes_pkg::MUL_W)'($signed(job_ff.dx[row_ff]));
         mb_in = (ltes_pkg::MUL_W)'($signed(job_ff.dx[col_in]));
      end
      prod_in = ma_in * mb_in;
   end

   // Divider operands: stiffness uses n << FRAC_BITS over 2|A2|.
   always_comb begin
      accabs_in  = acc_ff[ltes_pkg::ACC_W-1] ? (ltes_pkg::ACC_W)'(-acc_ff) : acc_ff;
      num_in     = (ltes_pkg::NUM_W)'(accabs_in) << FRAC_BITS;
      den_in     = (ltes_pkg::DEN_W)'({absa2_ff, 1'b0});
      num_neg_in = acc_ff[ltes_pkg::ACC_W-1] ^ a2neg_ff;
      out_free   = !rsp_valid_ff || rsp_pop;
      job_pop    = (state_ff == S_IDLE) && job_valid;
   end

   ltes_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start_ff),
      .num_neg (num_neg_in),
      .num_mag (num_in),
      .den     (den_in),
      .done    (div_done),
      .quo     (quo)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         div_start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         div_start_ff <= 1'b0;
         if (rsp_pop) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (job_valid) begin
                  job_ff   <= job_data;
                  a2neg_ff <= a2neg_in;
                  absa2_ff <= absa2_in;
                  degen_ff <= (a2_in == '0);
                  area_ff  <= area_in;
                  row_ff   <= 2'd0;
                  op_ff    <= 2'd0;
                  state_ff <= (a2_in == '0) ? S_EMIT : S_M1;
               end
            end
            S_M1: begin
               prod_ff  <= prod_in;
               state_ff <= S_M2;
            end
            S_M2: begin
               acc_ff   <= (ltes_pkg::ACC_W)'(prod_ff);
               prod_ff  <= prod_in;
               state_ff <= S_M3;
            end
            S_M3: begin
               // The load product arrives as a low and a high partial product.
               if (is_load) begin
                  acc_ff   <= acc_ff + ((ltes_pkg::ACC_W)'(prod_ff) <<< ltes_pkg::SPLIT_W);
                  state_ff <= S_RCP;
               end else begin
                  acc_ff       <= acc_ff + (ltes_pkg::ACC_W)'(prod_ff);
                  div_start_ff <= 1'b1;
                  state_ff     <= S_DIV;
               end
            end
            S_DIV: begin
               if (div_done) begin
                  col_ff[col_in] <= quo;
                  op_ff    <= op_ff + 2'd1;
                  state_ff <= S_M1;
               end
            end
            S_RCP: begin
               prod_ff  <= prod_in;
               state_ff <= S_FIX;
            end
            S_FIX: begin
               load_ff  <= load_in;
               state_ff <= S_EMIT;
            end
            S_EMIT: begin
               if (out_free) begin
                  rsp_valid_ff             <= 1'b1;
                  rsp_ff.row_index         <= row_ff;
                  rsp_ff.stiff_col_zero    <= degen_ff ? 32'd0 : col_ff[0];
                  rsp_ff.stiff_col_one     <= degen_ff ? 32'd0 : col_ff[1];
                  rsp_ff.stiff_col_two     <= degen_ff ? 32'd0 : col_ff[2];
                  rsp_ff.load_value        <= degen_ff ? 32'd0 : load_ff;
                  rsp_ff.tri_area          <= degen_ff ? 32'd0 : area_ff;
                  rsp_ff.degenerate        <= degen_ff;
                  rsp_ff.last_row          <= (row_ff == ltes_pkg::ROW_LAST);
                  if (row_ff == ltes_pkg::ROW_LAST) begin
                     state_ff <= S_IDLE;
                  end else begin
                     row_ff   <= row_ff + 2'd1;
                     op_ff    <= 2'd0;
                     state_ff <= degen_ff ? S_EMIT : S_M1;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_empty = !rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `LTES_ASSERT_IMPL(a_done_in_div, div_done, state_ff == S_DIV, "divider finished outside the divide step")
   `LTES_ASSERT_NEXT(a_emit_shows, state_ff == S_EMIT && out_free, rsp_valid_ff, "emitted row not shown")
   `LTES_ASSERT_IMPL(a_last_row, rsp_valid_ff && rsp_ff.last_row, rsp_ff.row_index == ltes_pkg::ROW_LAST, "last row flag on wrong row")

endmodule

// ===== hw/rtl/linear_triangle_element_stiffness_top.sv =====
// Top level of the P1 triangle element stiffness and load block.
// Depends on ltes_pkg, ltes_front, ltes_queue and ltes_back.
//
//   Channel   Ports                        Moves
//   request   push, full, req_data         one triangle per transaction
//   response  pop, empty, rsp_data         one matrix row per transaction
//
// In the back end a triangle that is not degenerate is taken, then runs three
// rows, each of three stiffness divisions (a product step on the shared 36x36
// multiplier and a pass through the single radix-2 divider), a load step that
// divides by three through a reciprocal product, and an emit step that waits
// for a free result register. A degenerate triangle only emits its rows. The
// front keeps accepting through its registered stages into a two-entry queue
// while the back works or stalls, until the queue fills. A stalled response
// holds in the output register, blocking the front only once the queue fills.
// Reset is synchronous and clears all handshake state; no clearing pass runs.
module linear_triangle_element_stiffness_top #(
   parameter int FRAC_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  ltes_pkg::req_type req_data,
   output logic              empty,
   input  logic              pop,
   output ltes_pkg::rsp_type rsp_data
);

   // Front to queue and queue to back transactions.
   logic              fq_push, fq_full, qb_valid, qb_pop;
   ltes_pkg::job_type fq_data, qb_data;

   // The front forms edge terms, source sums and twice the signed area.
   ltes_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .q_push   (fq_push),
      .q_full   (fq_full),
      .q_data   (fq_data)
   );

   // The queue lets the front run ahead while the back is busy.
   ltes_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (fq_push),
      .wdata (fq_data),
      .full  (fq_full),
      .valid (qb_valid),
      .rdata (qb_data),
      .pop   (qb_pop)
   );

   // The back runs the row products and divisions and owns the result register.
   ltes_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (qb_valid),
      .job_data  (qb_data),
      .job_pop   (qb_pop),
      .rsp_empty (empty),
      .rsp_pop   (pop),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== tb/sv/linear_triangle_element_stiffness_top_test.sv =====
// Self-checking testbench for the P1 triangle element stiffness and load block.
// Depends on ltes_pkg and linear_triangle_element_stiffness_top; needs nothing else.
`timescale 1ns / 100ps

module linear_triangle_element_stiffness_top_test;

   localparam int FRAC = 16;
   // Drain allowance after the last row.
   localparam int DRAIN_CYCLES = 1200;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    push = 1'b0;
   logic    pop = 1'b0;
   logic    full;
   logic    empty;
   ltes_pkg::req_type req_data = '0;
   ltes_pkg::rsp_type rsp_data;

   // Rows the block owes us, oldest first.
   ltes_pkg::rsp_type row_expect[$];
   int      error_count = 0;

   linear_triangle_element_stiffness_top #(.FRAC_BITS(FRAC)) u_dut (
      .clock(clock),
      .reset(reset),
      .push(push),
      .full(full),
      .req_data(req_data),
      .empty(empty),
      .pop(pop),
      .rsp_data(rsp_data)
   );

   always #10 clock = ~clock;

   // Ends a run that hangs; sized far beyond the slowest legal run.
   initial begin
      #20_000_000;
      $display("Verification failed");
      $finish;
   end

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // Exact quotient num/den rounded to nearest, ties away from zero, then
   // saturated to the signed 32-bit range. The denominator is positive.
   function automatic logic [31:0] round_sat(input logic signed [159:0] num,
                                             input logic signed [159:0] den);
      logic signed [159:0] mag;
      logic signed [159:0] quo;
      logic signed [159:0] rem;
      logic signed [159:0] neg_quo;
      mag = (num < 0) ? -num : num;
      quo = mag / den;
      rem = mag % den;
      if ((rem <<< 1) >= den) quo = quo + 1;
      if (num < 0) begin
         if (quo > 160'sd2147483648) return 32'h8000_0000;
         neg_quo = -quo;
         return neg_quo[31:0];
      end
      if (quo > 160'sd2147483647) return 32'h7FFF_FFFF;
      return quo[31:0];
   endfunction

   // Works out the three matrix rows that one triangle produces.
   task automatic predict_rows(input ltes_pkg::req_type tri_in);
      logic signed [159:0] vx[3];
      logic signed [159:0] vy[3];
      logic signed [159:0] vs[3];
      logic signed [159:0] edge_dx[3];
      logic signed [159:0] edge_dy[3];
      logic signed [159:0] twice_area;
      logic signed [159:0] stiff_den;
      logic signed [159:0] numer;
      logic [31:0]         kval[3];
      ltes_pkg::rsp_type   row;
      bit                  flat;
      vx[0] = $signed(tri_in.x_zero); vy[0] = $signed(tri_in.y_zero);
      vx[1] = $signed(tri_in.x_one);  vy[1] = $signed(tri_in.y_one);
      vx[2] = $signed(tri_in.x_two);  vy[2] = $signed(tri_in.y_two);
      vs[0] = $signed(tri_in.src_zero);
      vs[1] = $signed(tri_in.src_one);
      vs[2] = $signed(tri_in.src_two);
      for (int i = 0; i < 3; i++) begin
         edge_dy[i] = vy[(i + 1) % 3] - vy[(i + 2) % 3];
         edge_dx[i] = vx[(i + 2) % 3] - vx[(i + 1) % 3];
      end
      twice_area = (vx[1] - vx[0]) * (vy[2] - vy[0]) - (vx[2] - vx[0]) * (vy[1] - vy[0]);
      flat = (twice_area == 0);
      stiff_den = ((twice_area < 0) ? -twice_area : twice_area) <<< 1;
      for (int i = 0; i < 3; i++) begin
         row = '0;
         row.row_index = i[1:0];
         row.degenerate = flat;
         row.last_row = (i == 2);
         if (!flat) begin
            for (int j = 0; j < 3; j++) begin
               numer = (edge_dy[i] * edge_dy[j] + edge_dx[i] * edge_dx[j]) <<< FRAC;
               if (twice_area < 0) numer = -numer;
               kval[j] = round_sat(numer, stiff_den);
            end
            row.stiff_col_zero = kval[0];
            row.stiff_col_one = kval[1];
            row.stiff_col_two = kval[2];
            row.load_value = round_sat(twice_area *
                                       (2 * vs[i] + vs[(i + 1) % 3] + vs[(i + 2) % 3]),
                                       160'sd24 <<< (2 * FRAC));
            row.tri_area = round_sat(twice_area, 160'sd1 <<< (FRAC + 1));
         end
         row_expect.push_back(row);
      end
   endtask

   // Receiver: checks each popped row against the oldest expectation. The
   // stall pattern switches between free flow, light and heavy back pressure.
   int rx_cycle = 0;
   int stall_mode = 0;
   always @(posedge clock) begin
      ltes_pkg::rsp_type want;
      if (!reset && pop && !empty) begin
         if (row_expect.size() == 0) begin
            $display("MISMATCH unexpected row %0d at %0t", rsp_data.row_index, $realtime);
            error_count++;
         end else begin
            want = row_expect.pop_front();
            if (rsp_data.row_index !== want.row_index)
               report("row_index", rsp_data.row_index, want.row_index);
            if (rsp_data.stiff_col_zero !== want.stiff_col_zero)
               report("stiff_col_zero", rsp_data.stiff_col_zero, want.stiff_col_zero);
            if (rsp_data.stiff_col_one !== want.stiff_col_one)
               report("stiff_col_one", rsp_data.stiff_col_one, want.stiff_col_one);
            if (rsp_data.stiff_col_two !== want.stiff_col_two)
               report("stiff_col_two", rsp_data.stiff_col_two, want.stiff_col_two);
            if (rsp_data.load_value !== want.load_value)
               report("load_value", rsp_data.load_value, want.load_value);
            if (rsp_data.tri_area !== want.tri_area)
               report("tri_area", rsp_data.tri_area, want.tri_area);
            if (rsp_data.degenerate !== want.degenerate)
               report("degenerate", rsp_data.degenerate, want.degenerate);
            if (rsp_data.last_row !== want.last_row)
               report("last_row", rsp_data.last_row, want.last_row);
         end
      end
      rx_cycle++;
      if (rx_cycle % 200 == 0) stall_mode = $urandom_range(0, 2);
      case (stall_mode)
         0: pop <= 1'b1;
         1: pop <= ($urandom_range(0, 3) != 0);
         default: pop <= ($urandom_range(0, 7) == 0);
      endcase
   end

   // Directed stimulus. A flat row has its expectation typed in: a degenerate
   // triangle yields zero entries and the flag on every row.
   typedef struct {
      ltes_pkg::req_type tri_in;
      bit                flat;
   } stim_row_type;

   localparam logic [31:0] ONE = 32'h0001_0000;
   localparam logic [31:0] MAXV = 32'h7FFF_FFFF;
   localparam logic [31:0] MINV = 32'h8000_0000;

   stim_row_type stim_table[$];

   function automatic ltes_pkg::req_type make_tri(input logic [31:0] x0, y0, x1, y1, x2, y2,
                                                  input logic [31:0] s0, s1, s2);
      ltes_pkg::req_type t;
      t = '{x0, y0, x1, y1, x2, y2, s0, s1, s2};
      return t;
   endfunction

   // Holds push until the transaction completes. Full is looked at on the
   // falling edge, where it shows what the next rising edge will see.
   task automatic wait_accept(input ltes_pkg::req_type tri_in);
      push <= 1'b1;
      req_data <= tri_in;
      @(negedge clock);
      while (full) @(negedge clock);
      @(posedge clock);
   endtask

   // Sends one triangle and records the rows it owes.
   task automatic send_tri(input ltes_pkg::req_type tri_in);
      wait_accept(tri_in);
      predict_rows(tri_in);
   endtask

   // Random triangle: mostly small well-shaped ones, some collinear, some raw.
   function automatic ltes_pkg::req_type random_tri();
      ltes_pkg::req_type t;
      int      kind;
      int      span;
      int      k;
      logic signed [31:0] ddx;
      logic signed [31:0] ddy;
      kind = $urandom_range(0, 9);
      for (int i = 0; i < 9; i++) t[i*32 +: 32] = $urandom();
      if (kind < 6) begin
         span = (kind < 3) ? 20 : 27;
         t.x_zero = $signed($urandom_range(0, (1 << span) - 1)) - (1 << (span - 1));
         t.y_zero = $signed($urandom_range(0, (1 << span) - 1)) - (1 << (span - 1));
         t.x_one = $signed($urandom_range(0, (1 << span) - 1)) - (1 << (span - 1));
         t.y_one = $signed($urandom_range(0, (1 << span) - 1)) - (1 << (span - 1));
         t.x_two = $signed($urandom_range(0, (1 << span) - 1)) - (1 << (span - 1));
         t.y_two = $signed($urandom_range(0, (1 << span) - 1)) - (1 << (span - 1));
      end else if (kind < 8) begin
         // Collinear points, sometimes with a repeated vertex.
         ddx = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
         ddy = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
         k = $urandom_range(0, 6) - 3;
         t.x_zero = $signed($urandom_range(0, 1 << 24)) - (1 << 23);
         t.y_zero = $signed($urandom_range(0, 1 << 24)) - (1 << 23);
         t.x_one = t.x_zero + ddx;
         t.y_one = t.y_zero + ddy;
         t.x_two = t.x_zero + k * ddx;
         t.y_two = t.y_zero + k * ddy;
      end
      return t;
   endfunction

   initial begin
      int burst;
      stim_table.push_back('{make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1});
      stim_table.push_back('{make_tri(MAXV, MAXV, MAXV, MAXV, MAXV, MAXV,
                                      MAXV, MINV, MAXV), 1'b1});
      stim_table.push_back('{make_tri(MINV, MINV, 0, 0, MAXV, MAXV, MINV, MINV, MINV), 1'b0});
      stim_table.push_back('{make_tri(MINV, MINV, MAXV, MAXV, 0, 0, 1, 2, 3), 1'b1});
      // Unit right triangle, counter-clockwise, then the clockwise copy.
      stim_table.push_back('{make_tri(0, 0, ONE, 0, 0, ONE, ONE, ONE, ONE), 1'b0});
      stim_table.push_back('{make_tri(0, 0, 0, ONE, ONE, 0, ONE, ONE, ONE), 1'b0});
      // Largest area with extreme sources: saturated area and loads.
      stim_table.push_back('{make_tri(MINV, MINV, MAXV, MINV, MINV, MAXV,
                                      MAXV, MAXV, MAXV), 1'b0});
      stim_table.push_back('{make_tri(MINV, MINV, MINV, MAXV, MAXV, MINV,
                                      MINV, MINV, MINV), 1'b0});
      stim_table.push_back('{make_tri(MINV, MAXV, MAXV, MINV, MAXV, MAXV,
                                      MINV, MAXV, 0), 1'b0});
      // Sliver: one least-significant bit of height over a long base.
      stim_table.push_back('{make_tri(MINV, 0, MAXV, 0, 0, 1, ONE, 0, MINV), 1'b0});
      stim_table.push_back('{make_tri(0, 0, 1, 0, 0, 1, MAXV, MAXV, MAXV), 1'b0});
      stim_table.push_back('{make_tri(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF,
                                      32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 1, 0), 1'b0});
      stim_table.push_back('{make_tri(ONE, ONE, 2 * ONE, 2 * ONE, 3 * ONE, 3 * ONE,
                                      5, 6, 7), 1'b1});

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (stim_table[n]) begin
         if (stim_table[n].flat) begin
            wait_accept(stim_table[n].tri_in);
            for (int r = 0; r < 3; r++)
               row_expect.push_back('{r[1:0], 0, 0, 0, 0, 0, 1'b1, r == 2});
         end else begin
            send_tri(stim_table[n].tri_in);
         end
         if ($urandom_range(0, 2) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end

      // Random part in bursts; halfway the sender holds off until the block drains.
      for (int n = 0; n < 96; n += burst) begin
         burst = $urandom_range(1, 8);
         for (int b = 0; b < burst; b++) send_tri(random_tri());
         push <= 1'b0;
         if (n < 48 && n + burst >= 48) begin
            @(posedge clock);
            while (row_expect.size() != 0) @(posedge clock);
         end
         repeat ($urandom_range(1, 40)) @(posedge clock);
      end

      @(posedge clock);
      while (row_expect.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && row_expect.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/ltes_pkg.sv
hw/rtl/ltes_front.sv
hw/rtl/ltes_queue.sv
hw/rtl/ltes_div.sv
hw/rtl/ltes_back.sv
hw/rtl/linear_triangle_element_stiffness_top.sv
tb/sv/linear_triangle_element_stiffness_top_test.sv
